@@ sv/quaternion_to_rotation_matrix_assert.svh @@
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define Q2RM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("q2rm check failed");

// next-cycle implication under reset
`define Q2RM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("q2rm check failed");

`else

`define Q2RM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define Q2RM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/q2rm_pkg.sv @@
// ----------------------------------------------------------------------------
// q2rm_pkg
// beat types and fixed widths for the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
package q2rm_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int NUM_ELEM = 9;
    // product of two components
    localparam int PROD_W   = 2 * IN_W;
    // signed numerator, up to +/- 2^32
    localparam int NUM_W    = PROD_W + 2;
    // squared length and numerator magnitude, up to 2^32
    localparam int MAG_W    = PROD_W + 1;

    // input beat
    typedef struct packed {
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
        logic signed [IN_W-1:0] quat_w;
    } t_quat;

    // result beat
    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
        logic                    zero_length;
    } t_rot;

endpackage

@@ sv/quaternion_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalized quaternion to 3x3 rotation matrix, fully pipelined
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_quat and raise start; the beat is taken at any edge where start
//   is high and busy is low. busy is always low, so a new quaternion can be
//   taken on every cycle: throughput is one beat per clock.
//   Each element is round(num * 2^OUT_FRAC_BITS / n), n = |q|^2, computed
//   by a restoring divider with one quotient bit per stage, nine lanes wide.
//   The pipeline has four stages of input, products, sums and magnitude,
//   OUT_FRAC_BITS + 2 divider stages, and the output register.
//   Each result is shown on o_result for one cycle with o_done high; the
//   receiver cannot stall, so nothing holds the pipe.
//   An all-zero quaternion yields the identity with zero_length set.
//   Reset (synchronous, active low) clears all valid bits; items in flight
//   are dropped and no result follows them.
// ----------------------------------------------------------------------------
`include "quaternion_to_rotation_matrix_assert.svh"

module quaternion_to_rotation_matrix
    import q2rm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_quat i_quat,
    output logic  o_done,
    output t_rot  o_result
);

    // quotient bits before rounding: one integer bit and OUT_FRAC_BITS + 1 fraction
    localparam int QW   = OUT_FRAC_BITS + 2;
    localparam int NSTG = OUT_FRAC_BITS + 2;
    localparam int EW   = (QW > OUT_W + 1) ? QW : OUT_W + 1;
    localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (OUT_W - 1));
    localparam logic [EW-1:0] UNITY   = EW'(64'd1 << OUT_FRAC_BITS);
    localparam logic [OUT_W-1:0] DIAG_ONE =
        (UNITY > POS_LIM) ? POS_LIM[OUT_W-1:0] : UNITY[OUT_W-1:0];

    typedef logic signed [NUM_W-1:0] t_num;

    function automatic t_num ext_p(input logic signed [PROD_W-1:0] p);
        ext_p = {{(NUM_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

    assign busy = 1'b0;

    // stage 1: input register
    logic  r_v1;
    t_quat r_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_q1 <= i_quat;
    end

    // stage 2: ten component products
    logic r_v2;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_xx <= r_q1.quat_x * r_q1.quat_x;
        r_yy <= r_q1.quat_y * r_q1.quat_y;
        r_zz <= r_q1.quat_z * r_q1.quat_z;
        r_ww <= r_q1.quat_w * r_q1.quat_w;
        r_xy <= r_q1.quat_x * r_q1.quat_y;
        r_zw <= r_q1.quat_z * r_q1.quat_w;
        r_xz <= r_q1.quat_x * r_q1.quat_z;
        r_yw <= r_q1.quat_y * r_q1.quat_w;
        r_yz <= r_q1.quat_y * r_q1.quat_z;
        r_xw <= r_q1.quat_x * r_q1.quat_w;
    end

    // stage 3: squared length and nine signed numerators
    logic             r_v3;
    logic [MAG_W-1:0] r_n3;
    t_num             r_num3 [NUM_ELEM];
    t_num             n_len;

    assign n_len = ext_p(r_xx) + ext_p(r_yy) + ext_p(r_zz) + ext_p(r_ww);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_n3      <= n_len[MAG_W-1:0];
        r_num3[0] <= ext_p(r_ww) + ext_p(r_xx) - ext_p(r_yy) - ext_p(r_zz);
        r_num3[1] <= (ext_p(r_xy) - ext_p(r_zw)) <<< 1;
        r_num3[2] <= (ext_p(r_xz) + ext_p(r_yw)) <<< 1;
        r_num3[3] <= (ext_p(r_xy) + ext_p(r_zw)) <<< 1;
        r_num3[4] <= ext_p(r_ww) + ext_p(r_yy) - ext_p(r_xx) - ext_p(r_zz);
        r_num3[5] <= (ext_p(r_yz) - ext_p(r_xw)) <<< 1;
        r_num3[6] <= (ext_p(r_xz) - ext_p(r_yw)) <<< 1;
        r_num3[7] <= (ext_p(r_yz) + ext_p(r_xw)) <<< 1;
        r_num3[8] <= ext_p(r_ww) + ext_p(r_zz) - ext_p(r_xx) - ext_p(r_yy);
    end

    // stage 4: sign and magnitude, zero-length detect
    logic             r_v4;
    logic             r_z4;
    logic [MAG_W-1:0] r_n4;
    logic [MAG_W-1:0] r_mag4 [NUM_ELEM];
    logic             r_neg4 [NUM_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_z4 <= (r_n3 == '0);
        r_n4 <= r_n3;
    end

    for (genvar e = 0; e < NUM_ELEM; e++) begin : g_abs
        t_num n_abs;
        assign n_abs = r_num3[e][NUM_W-1] ? -r_num3[e] : r_num3[e];
        always_ff @(posedge i_clk) begin
            r_neg4[e] <= r_num3[e][NUM_W-1];
            r_mag4[e] <= n_abs[MAG_W-1:0];
        end
    end

    // divider stages: one quotient bit per stage, nine lanes
    logic             r_dv   [NSTG];
    logic             r_dz   [NSTG];
    logic [MAG_W-1:0] r_dn   [NSTG];
    logic [MAG_W-1:0] r_rem  [NSTG][NUM_ELEM];
    logic [QW-1:0]    r_quo  [NSTG][NUM_ELEM];
    logic             r_dneg [NSTG][NUM_ELEM];

    for (genvar s = 0; s < NSTG; s++) begin : g_div
        logic             src_v;
        logic             src_z;
        logic [MAG_W-1:0] src_n;

        if (s == 0) begin : g_src0
            assign src_v = r_v4;
            assign src_z = r_z4;
            assign src_n = r_n4;
        end else begin : g_srcn
            assign src_v = r_dv[s-1];
            assign src_z = r_dz[s-1];
            assign src_n = r_dn[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else begin
                r_dv[s] <= src_v;
            end
            r_dz[s] <= src_z;
            r_dn[s] <= src_n;
        end

        for (genvar e = 0; e < NUM_ELEM; e++) begin : g_lane
            logic [MAG_W:0]   n_trial;
            logic [MAG_W:0]   n_diff;
            logic [QW-1:0]    n_qin;
            logic             n_nin;

            // trial remainder: magnitude itself first, then doubled remainder
            if (s == 0) begin : g_t0
                assign n_trial = {1'b0, r_mag4[e]};
                assign n_qin   = '0;
                assign n_nin   = r_neg4[e];
            end else begin : g_tn
                assign n_trial = {r_rem[s-1][e], 1'b0};
                assign n_qin   = r_quo[s-1][e];
                assign n_nin   = r_dneg[s-1][e];
            end

            assign n_diff = n_trial - {1'b0, src_n};

            always_ff @(posedge i_clk) begin
                r_dneg[s][e] <= n_nin;
                if (!n_diff[MAG_W]) begin
                    r_rem[s][e] <= n_diff[MAG_W-1:0];
                    r_quo[s][e] <= {n_qin[QW-2:0], 1'b1};
                end else begin
                    r_rem[s][e] <= n_trial[MAG_W-1:0];
                    r_quo[s][e] <= {n_qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    // output stage: round half up, sign, saturate, identity override
    logic [OUT_W-1:0] n_elem [NUM_ELEM];
    logic             r_done;
    logic [OUT_W-1:0] r_elem [NUM_ELEM];
    logic             r_zero;

    for (genvar e = 0; e < NUM_ELEM; e++) begin : g_out
        logic [QW-1:0] n_rnd;
        logic [EW-1:0] n_ext;
        logic [EW-1:0] n_neg_v;

        assign n_rnd   = (r_quo[NSTG-1][e] + QW'(1)) >> 1;
        assign n_ext   = EW'(n_rnd);
        assign n_neg_v = -((n_ext > NEG_LIM) ? NEG_LIM : n_ext);

        always_comb begin
            if (r_dz[NSTG-1]) begin
                n_elem[e] = (e == 0 || e == 4 || e == 8) ? DIAG_ONE : '0;
            end else if (r_dneg[NSTG-1][e] && n_ext != '0) begin
                n_elem[e] = n_neg_v[OUT_W-1:0];
            end else begin
                n_elem[e] = (n_ext > POS_LIM) ? POS_LIM[OUT_W-1:0] : n_ext[OUT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_elem[e] <= n_elem[e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[NSTG-1];
        end
        r_zero <= r_dz[NSTG-1];
    end

    assign o_done               = r_done;
    assign o_result.r00         = r_elem[0];
    assign o_result.r01         = r_elem[1];
    assign o_result.r02         = r_elem[2];
    assign o_result.r10         = r_elem[3];
    assign o_result.r11         = r_elem[4];
    assign o_result.r12         = r_elem[5];
    assign o_result.r20         = r_elem[6];
    assign o_result.r21         = r_elem[7];
    assign o_result.r22         = r_elem[8];
    assign o_result.zero_length = r_zero;

    // checks
    localparam logic signed [OUT_W+1:0] HI_BOUND = (OUT_W + 2)'(DIAG_ONE);
    localparam logic signed [OUT_W+1:0] LO_BOUND =
        (UNITY > POS_LIM) ? -(OUT_W + 2)'(NEG_LIM) : -(OUT_W + 2)'(UNITY);

    `Q2RM_ASSERT_NOW(a_identity, i_clk, i_rst_n, o_done && o_result.zero_length, o_result.r00 == DIAG_ONE && o_result.r11 == DIAG_ONE && o_result.r22 == DIAG_ONE && o_result.r01 == '0 && o_result.r10 == '0 && o_result.r12 == '0)
    `Q2RM_ASSERT_NOW(a_r00_range, i_clk, i_rst_n, o_done, (OUT_W + 2)'(o_result.r00) <= HI_BOUND && (OUT_W + 2)'(o_result.r00) >= LO_BOUND)
    `Q2RM_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_dv[NSTG-1], o_done)

endmodule
